// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that holds at every clock edge outside reset.
`define CRA_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Next-cycle implication: ante at one edge gives cons at the following edge.
`define CRA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`else

`define CRA_ASSERT(name, clk, rst_n, prop, msg)
`define CRA_ASSERT_NXT(name, clk, rst_n, ante, cons, msg)

`endif

`endif

// ===== rtl/core/cra_pkg.sv =====
package cra_pkg;

	localparam int MAX_VOICES = 4;
	localparam int FREQ_W     = 24;
	localparam int LVL_W      = 32;
	localparam int COEFF_W    = 26;
	localparam int SCALE_W    = 32;
	localparam int CNT_W      = 3;
	localparam int ADDR_W     = 4;
	localparam int DATA_W     = 32;

	localparam int PROD_W  = FREQ_W + SCALE_W;     // |f| * rate_scale
	localparam int STEP_W  = LVL_W - 1;            // unsigned step magnitude
	localparam int DIFF_W  = LVL_W + 1;            // target - smoothed
	localparam int SPROD_W = DIFF_W + COEFF_W + 1; // diff * coeff

	localparam logic [COEFF_W-1:0] COEFF_RST = COEFF_W'(42949673);
	localparam logic [SCALE_W-1:0] SCALE_RST = SCALE_W'(91625969);
	localparam logic [CNT_W-1:0]   COUNT_RST = CNT_W'(4);

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_COEFF = 2'd0;
	localparam logic [1:0] REG_SCALE = 2'd1;
	localparam logic [1:0] REG_COUNT = 2'd2;

	typedef logic signed [LVL_W-1:0] lvl_t;

	localparam lvl_t LVL_ONE     = lvl_t'(32'sd1 <<< 28);
	localparam lvl_t LVL_NEG_ONE = -LVL_ONE;
	localparam lvl_t LVL_MAX     = {1'b0, {(LVL_W-1){1'b1}}};
	localparam lvl_t LVL_MIN     = {1'b1, {(LVL_W-1){1'b0}}};

	typedef struct packed {
		logic signed [FREQ_W-1:0] up_freq_a;
		logic signed [FREQ_W-1:0] down_freq_a;
		logic signed [FREQ_W-1:0] up_freq_b;
		logic signed [FREQ_W-1:0] down_freq_b;
		logic signed [FREQ_W-1:0] up_freq_c;
		logic signed [FREQ_W-1:0] down_freq_c;
		logic signed [FREQ_W-1:0] up_freq_d;
		logic signed [FREQ_W-1:0] down_freq_d;
	} tick_t;

	typedef struct packed {
		logic signed [LVL_W-1:0] level_a;
		logic signed [LVL_W-1:0] level_b;
		logic signed [LVL_W-1:0] level_c;
		logic signed [LVL_W-1:0] level_d;
	} levels_t;

	typedef struct packed {
		logic mul_en;
		logic smo_en;
		logic commit;
	} lane_ctrl_t;

	// clamp a 33-bit sum into the signed 32-bit range
	function automatic lvl_t sat_lvl(input logic signed [LVL_W:0] v);
		if (v[LVL_W] != v[LVL_W-1]) begin
			return v[LVL_W] ? LVL_MIN : LVL_MAX;
		end
		return v[LVL_W-1:0];
	endfunction

	// round(prod / 2^20), half up, saturated to 2^31-1
	function automatic logic [STEP_W-1:0] step_from_prod(input logic [PROD_W-1:0] p);
		logic [PROD_W:0]    rnd;
		logic [PROD_W-20:0] q;
		rnd = {1'b0, p} + (PROD_W+1)'(1 << 19);
		q   = rnd[PROD_W:20];
		if (q[PROD_W-20:STEP_W] != '0) begin
			return {STEP_W{1'b1}};
		end
		return q[STEP_W-1:0];
	endfunction

	// y + floor((diff*coeff + 2^31) / 2^32), saturated
	function automatic lvl_t smooth_next(input lvl_t y, input logic signed [SPROD_W-1:0] p);
		logic signed [SPROD_W:0]    t;
		logic signed [SPROD_W-32:0] q;
		logic signed [LVL_W:0]      s;
		t = {p[SPROD_W-1], p} + {{(SPROD_W-31){1'b0}}, 1'b1, 31'b0};
		q = t[SPROD_W:32];
		s = (LVL_W+1)'(y) + (LVL_W+1)'(q);
		return sat_lvl(s);
	endfunction

endpackage

// ===== rtl/core/coupled_ramp_oscillator_bank_core.sv =====
// Four-voice coupled ramp oscillator bank.
// tick channel: one item per sample tick with up and down rates (Q16.8 Hz) for
// each voice; levels channel: one item per tick with the new level of every
// voice in Q4.28, zero for voices beyond voice_count.
// Both channels use valid/stall; an item moves on an edge with valid high and
// stall low. Each voice is a lane with its own rate multipliers and smoother;
// a merge stage resolves the neighbor comparisons and holds the output item.
// Sequencing: an accepted tick passes the two multiplier stages (rate
// scaling, then smoothing) and the commit step; levels is registered at the
// commit, and tick_stall drops with it, so no new tick enters before that commit.
// While levels is stalled the finished item waits in its output register; the
// next tick is computed up to its commit step and then waits there.
// Reset clears all voice levels, steps and smoothed rates to zero and loads
// the register defaults; the user must write configuration through the APB
// port only while no tick is in flight; the block itself does not enforce this.
`include "assert_macros.svh"

module coupled_ramp_oscillator_bank_core #(
	parameter int VOICES = cra_pkg::MAX_VOICES
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  cra_pkg::tick_t                tick,
	output logic                          levels_valid,
	input  logic                          levels_stall,
	output cra_pkg::levels_t              levels,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cra_pkg::ADDR_W-1:0]    paddr,
	input  logic [cra_pkg::DATA_W-1:0]    pwdata,
	output logic [cra_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);
	import cra_pkg::*;

	localparam logic [1:0] PH_IDLE   = 2'd0;
	localparam logic [1:0] PH_MUL    = 2'd1;
	localparam logic [1:0] PH_SMO    = 2'd2;
	localparam logic [1:0] PH_COMMIT = 2'd3;

	logic [COEFF_W-1:0] coeff_q;
	logic [SCALE_W-1:0] scale_q;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   count_n;
	logic [1:0]         phase_q;
	logic               commit;
	lane_ctrl_t         ctrl;
	tick_t              tick_q;

	logic signed [FREQ_W-1:0] up_f [MAX_VOICES];
	logic signed [FREQ_W-1:0] dn_f [MAX_VOICES];

	lvl_t              level      [VOICES];
	lvl_t              next_level [VOICES];
	logic [VOICES-1:0] active, turn_up, turn_dn;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_q <= COEFF_RST;
			scale_q <= SCALE_RST;
			count_q <= COUNT_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				REG_COEFF: coeff_q <= pwdata[COEFF_W-1:0];
				REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
				REG_COUNT: count_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_COEFF: prdata = DATA_W'(coeff_q);
			REG_SCALE: prdata = DATA_W'(scale_q);
			REG_COUNT: prdata = DATA_W'(count_q);
			default:   prdata = '0;
		endcase
	end

	// zero voices acts as one, too many as all
	assign count_n = (count_q == '0) ? CNT_W'(1) :
		(count_q > CNT_W'(VOICES)) ? CNT_W'(VOICES) : count_q;

	// item sequencing
	assign tick_stall = (phase_q != PH_IDLE);
	assign commit     = (phase_q == PH_COMMIT) && (!levels_valid || !levels_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			case (phase_q)
				PH_IDLE:   if (tick_valid) phase_q <= PH_MUL;
				PH_MUL:    phase_q <= PH_SMO;
				PH_SMO:    phase_q <= PH_COMMIT;
				PH_COMMIT: if (commit) phase_q <= PH_IDLE;
				default:   phase_q <= PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_q <= tick;
		end
	end

	assign ctrl.mul_en = (phase_q == PH_MUL);
	assign ctrl.smo_en = (phase_q == PH_SMO);
	assign ctrl.commit = commit;

	assign up_f[0] = tick_q.up_freq_a;
	assign dn_f[0] = tick_q.down_freq_a;
	assign up_f[1] = tick_q.up_freq_b;
	assign dn_f[1] = tick_q.down_freq_b;
	assign up_f[2] = tick_q.up_freq_c;
	assign dn_f[2] = tick_q.down_freq_c;
	assign up_f[3] = tick_q.up_freq_d;
	assign dn_f[3] = tick_q.down_freq_d;

	for (genvar k = 0; k < VOICES; k++) begin : g_lane
		cra_lane u_lane (
			.clk          (clk),
			.arst_n       (arst_n),
			.ctrl         (ctrl),
			.active       (active[k]),
			.up_freq      (up_f[k]),
			.down_freq    (dn_f[k]),
			.rate_scale   (scale_q),
			.smooth_coeff (coeff_q),
			.turn_up      (turn_up[k]),
			.turn_dn      (turn_dn[k]),
			.level        (level[k]),
			.next_level   (next_level[k])
		);
	end

	cra_merge #(
		.VOICES (VOICES)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.commit       (commit),
		.count        (count_n),
		.level        (level),
		.next_level   (next_level),
		.active       (active),
		.turn_up      (turn_up),
		.turn_dn      (turn_dn),
		.levels_stall (levels_stall),
		.levels_valid (levels_valid),
		.levels       (levels)
	);

	`CRA_ASSERT_NXT(a_accept_starts, clk, arst_n, tick_valid && !tick_stall, phase_q == PH_MUL, "accepted item did not start the rate multiply")
	`CRA_ASSERT_NXT(a_mul_to_smo, clk, arst_n, phase_q == PH_MUL, phase_q == PH_SMO, "rate multiply not followed by smoothing")
	`CRA_ASSERT_NXT(a_commit_holds, clk, arst_n, phase_q == PH_COMMIT && levels_valid && levels_stall, phase_q == PH_COMMIT && levels_valid, "commit went ahead over a stalled output item")
	`CRA_ASSERT(a_valid_from_commit, clk, arst_n, $rose(levels_valid) |-> $past(phase_q) == PH_COMMIT, "output item appeared without a commit")

endmodule

// ===== rtl/core/cra_lane.sv =====
module cra_lane (
	input  logic                              clk,
	input  logic                              arst_n,
	input  cra_pkg::lane_ctrl_t               ctrl,
	input  logic                              active,
	input  logic signed [cra_pkg::FREQ_W-1:0] up_freq,
	input  logic signed [cra_pkg::FREQ_W-1:0] down_freq,
	input  logic [cra_pkg::SCALE_W-1:0]       rate_scale,
	input  logic [cra_pkg::COEFF_W-1:0]       smooth_coeff,
	input  logic                              turn_up,
	input  logic                              turn_dn,
	output cra_pkg::lvl_t                     level,
	output cra_pkg::lvl_t                     next_level
);
	import cra_pkg::*;

	lvl_t level_q, step_q, sm_up_q, sm_dn_q;

	logic [FREQ_W-1:0]         up_mag, dn_mag;
	logic [PROD_W-1:0]         up_prod_s1, dn_prod_s1;
	logic [STEP_W-1:0]         up_tgt, dn_tgt;
	logic signed [DIFF_W-1:0]  up_diff, dn_diff;
	logic signed [SPROD_W-1:0] up_sprod_s2, dn_sprod_s2;
	lvl_t                      up_next, dn_next;

	// magnitude; the most negative code maps to 2^23
	assign up_mag = up_freq[FREQ_W-1] ? FREQ_W'(-up_freq) : FREQ_W'(up_freq);
	assign dn_mag = down_freq[FREQ_W-1] ? FREQ_W'(-down_freq) : FREQ_W'(down_freq);

	always_ff @(posedge clk) begin
		if (ctrl.mul_en) begin
			up_prod_s1 <= PROD_W'(up_mag) * PROD_W'(rate_scale);
			dn_prod_s1 <= PROD_W'(dn_mag) * PROD_W'(rate_scale);
		end
	end

	assign up_tgt  = step_from_prod(up_prod_s1);
	assign dn_tgt  = step_from_prod(dn_prod_s1);
	assign up_diff = DIFF_W'({2'b00, up_tgt}) - DIFF_W'(sm_up_q);
	// down target is the negated step
	assign dn_diff = DIFF_W'(0) - DIFF_W'({2'b00, dn_tgt}) - DIFF_W'(sm_dn_q);

	always_ff @(posedge clk) begin
		if (ctrl.smo_en) begin
			up_sprod_s2 <= SPROD_W'(up_diff) * SPROD_W'($signed({1'b0, smooth_coeff}));
			dn_sprod_s2 <= SPROD_W'(dn_diff) * SPROD_W'($signed({1'b0, smooth_coeff}));
		end
	end

	assign up_next    = smooth_next(sm_up_q, up_sprod_s2);
	assign dn_next    = smooth_next(sm_dn_q, dn_sprod_s2);
	assign next_level = sat_lvl((LVL_W+1)'(level_q) + (LVL_W+1)'(step_q));
	assign level      = level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			step_q  <= '0;
			sm_up_q <= '0;
			sm_dn_q <= '0;
		end else if (ctrl.commit && active) begin
			level_q <= next_level;
			sm_up_q <= up_next;
			sm_dn_q <= dn_next;
			if (turn_up) begin
				step_q <= up_next;
			end else if (turn_dn) begin
				step_q <= dn_next;
			end
		end
	end

endmodule

// ===== rtl/core/cra_merge.sv =====
module cra_merge #(
	parameter int VOICES = cra_pkg::MAX_VOICES
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           commit,
	input  logic [cra_pkg::CNT_W-1:0]      count,
	input  cra_pkg::lvl_t                  level [VOICES],
	input  cra_pkg::lvl_t                  next_level [VOICES],
	output logic [VOICES-1:0]              active,
	output logic [VOICES-1:0]              turn_up,
	output logic [VOICES-1:0]              turn_dn,
	input  logic                           levels_stall,
	output logic                           levels_valid,
	output cra_pkg::levels_t               levels
);
	import cra_pkg::*;

	lvl_t    below [VOICES];
	lvl_t    above [VOICES];
	lvl_t    lv    [MAX_VOICES];
	levels_t levels_d;
	logic    valid_q;
	levels_t levels_q;

	for (genvar k = 0; k < VOICES; k++) begin : g_turn
		assign active[k] = CNT_W'(k) < count;

		// lower neighbor still holds its old level this tick
		if (k + 1 < VOICES) begin : g_below
			assign below[k] = (CNT_W'(k + 1) < count) ? level[k + 1] : LVL_NEG_ONE;
		end else begin : g_floor
			assign below[k] = LVL_NEG_ONE;
		end

		// upper neighbor has already moved this tick
		if (k > 0) begin : g_above
			assign above[k] = next_level[k - 1];
		end else begin : g_ceil
			assign above[k] = LVL_ONE;
		end

		assign turn_up[k] = (next_level[k] <= below[k]) || (next_level[k] <= LVL_NEG_ONE);
		assign turn_dn[k] = !turn_up[k] &&
			((next_level[k] >= above[k]) || (next_level[k] >= LVL_ONE));
	end

	for (genvar k = 0; k < MAX_VOICES; k++) begin : g_out
		if (k < VOICES) begin : g_used
			assign lv[k] = active[k] ? next_level[k] : '0;
		end else begin : g_unused
			assign lv[k] = '0;
		end
	end

	always_comb begin
		levels_d.level_a = lv[0];
		levels_d.level_b = lv[1];
		levels_d.level_c = lv[2];
		levels_d.level_d = lv[3];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (commit) begin
			valid_q <= 1'b1;
		end else if (!levels_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			levels_q <= levels_d;
		end
	end

	assign levels_valid = valid_q;
	assign levels       = levels_q;

endmodule
